// ===== rtl/llsm_pkg.sv =====
// shared constants, command and status codes, and controller/datapath structs
package llsm_pkg;

	// defaults for the top-level parameters
	localparam int SLOTS_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed beat field widths
	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int SLOT_W   = 8;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;
	localparam int OP_W     = 4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT_AFTER = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE_AFTER = 3'd4;
	localparam logic [CMD_W-1:0] CMD_POP_BACK     = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ         = 3'd6;
	localparam logic [CMD_W-1:0] CMD_INIT         = 3'd7;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

	// datapath operations issued by the controller
	localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD        = 4'd1;
	localparam logic [OP_W-1:0] OP_RD_POS      = 4'd2;
	localparam logic [OP_W-1:0] OP_RD_FREE     = 4'd3;
	localparam logic [OP_W-1:0] OP_RD_HEAD     = 4'd4;
	localparam logic [OP_W-1:0] OP_RD_DEL      = 4'd5;
	localparam logic [OP_W-1:0] OP_ALLOC_BACK  = 4'd6;
	localparam logic [OP_W-1:0] OP_ALLOC_FRONT = 4'd7;
	localparam logic [OP_W-1:0] OP_ALLOC_AFTER = 4'd8;
	localparam logic [OP_W-1:0] OP_LINK_TAIL   = 4'd9;
	localparam logic [OP_W-1:0] OP_LINK_POS    = 4'd10;
	localparam logic [OP_W-1:0] OP_POP_FRONT   = 4'd11;
	localparam logic [OP_W-1:0] OP_UNLINK      = 4'd12;
	localparam logic [OP_W-1:0] OP_FREE_PTR    = 4'd13;
	localparam logic [OP_W-1:0] OP_WALK        = 4'd14;

	// controller to datapath
	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic                fin;
		logic [STATUS_W-1:0] fin_status;
	} llsm_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             pos_ok;
		logic             used;
		logic             link_zero;
		logic             link_is_tail;
		logic             free_zero;
		logic             head_zero;
		logic             walk_last;
		logic             out_stall;
	} llsm_sts_t;

endpackage

// ===== rtl/llsm_cmd_if.sv =====
// command channel: valid/ready handshake with the command beat
interface llsm_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [llsm_pkg::CMD_W-1:0]        cmd;
	logic signed [llsm_pkg::VALUE_W-1:0] value;
	logic [llsm_pkg::POS_W-1:0]        position;

	modport source (output valid, output cmd, output value, output position, input ready);
	modport sink (input valid, input cmd, input value, input position, output ready);
endinterface

// ===== rtl/llsm_rsp_if.sv =====
// result channel: valid/ready handshake with the result beat
interface llsm_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [llsm_pkg::SLOT_W-1:0]         slot;
	logic signed [llsm_pkg::VALUE_W-1:0] read_value;
	logic [llsm_pkg::COUNT_W-1:0]        element_count;
	logic [llsm_pkg::STATUS_W-1:0]       status;

	modport source (output valid, output slot, output read_value, output element_count,
		output status, input ready);
	modport sink (input valid, input slot, input read_value, input element_count,
		input status, output ready);
endinterface

// ===== rtl/llsm_datapath.sv =====
// list datapath: node and value memories, list pointers, walker and result register
module llsm_datapath #(
	parameter int SLOTS      = llsm_pkg::SLOTS_DEF,
	parameter int DATA_WIDTH = llsm_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [llsm_pkg::CMD_W-1:0]          req_cmd,
	input  logic signed [llsm_pkg::VALUE_W-1:0] req_value,
	input  logic [llsm_pkg::POS_W-1:0]          req_position,
	input  logic                                rsp_ready,
	output logic                                rsp_valid,
	output logic [llsm_pkg::SLOT_W-1:0]         rsp_slot,
	output logic signed [llsm_pkg::VALUE_W-1:0] rsp_read_value,
	output logic [llsm_pkg::COUNT_W-1:0]        rsp_element_count,
	output logic [llsm_pkg::STATUS_W-1:0]       rsp_status,
	input  llsm_pkg::llsm_ctl_t                 ctl,
	output llsm_pkg::llsm_sts_t                 sts
);

	localparam int SW      = $clog2(SLOTS);
	localparam int SLOT_W  = llsm_pkg::SLOT_W;
	localparam int VALUE_W = llsm_pkg::VALUE_W;
	localparam int COUNT_W = llsm_pkg::COUNT_W;

	typedef logic [SW-1:0] idx_t;

	localparam idx_t IDX_ONE  = idx_t'(1);
	localparam idx_t IDX_TWO  = idx_t'(2);
	localparam idx_t IDX_LAST = idx_t'(SLOTS - 1);

	// node entry is {used, link}
	logic [SW:0]           node_mem [SLOTS];
	logic [DATA_WIDTH-1:0] val_mem [SLOTS];

	logic [llsm_pkg::CMD_W-1:0] cmd_q;
	logic [llsm_pkg::POS_W-1:0] pos_q;
	logic [DATA_WIDTH-1:0]      val_q;
	idx_t                       head_q;
	idx_t                       tail_q;
	idx_t                       free_q;
	idx_t                       count_q;
	idx_t                       walk_q;
	idx_t                       ptr_q;
	idx_t                       plink_q;
	logic [SW:0]                node_rd_q;
	logic [DATA_WIDTH-1:0]      val_rd_q;
	logic                       out_valid_q;

	idx_t        pos_idx;
	idx_t        rd_link;
	logic        rd_used;
	logic        walk_last;
	idx_t        walk_link;
	logic        rd_en;
	idx_t        rd_addr;
	logic        wr_en;
	idx_t        wr_addr;
	logic [SW:0] wr_data;
	logic        val_we;
	idx_t        val_waddr;
	logic        fin_ok;

	assign pos_idx   = idx_t'(pos_q);
	assign rd_link   = node_rd_q[SW-1:0];
	assign rd_used   = node_rd_q[SW];
	assign walk_last = (walk_q == IDX_LAST);
	assign walk_link = (walk_q >= IDX_TWO && !walk_last) ? walk_q + IDX_ONE : '0;

	// read address select
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_idx;
		unique case (ctl.op)
			llsm_pkg::OP_RD_POS: begin
				rd_en   = 1'b1;
				rd_addr = pos_idx;
			end
			llsm_pkg::OP_RD_FREE: begin
				rd_en   = 1'b1;
				rd_addr = free_q;
			end
			llsm_pkg::OP_RD_HEAD: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
			end
			llsm_pkg::OP_RD_DEL: begin
				rd_en   = 1'b1;
				rd_addr = rd_link;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// write address and data select
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = ptr_q;
		wr_data   = {1'b1, idx_t'(0)};
		val_we    = 1'b0;
		val_waddr = ptr_q;
		unique case (ctl.op)
			llsm_pkg::OP_ALLOC_BACK: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, idx_t'(0)};
				val_we  = 1'b1;
			end
			llsm_pkg::OP_ALLOC_FRONT: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, head_q};
				val_we  = 1'b1;
			end
			llsm_pkg::OP_ALLOC_AFTER: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, plink_q};
				val_we  = 1'b1;
			end
			llsm_pkg::OP_LINK_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = tail_q;
				wr_data = {1'b1, ptr_q};
			end
			llsm_pkg::OP_LINK_POS: begin
				wr_en   = 1'b1;
				wr_addr = pos_idx;
				wr_data = {1'b1, ptr_q};
			end
			llsm_pkg::OP_UNLINK: begin
				wr_en   = 1'b1;
				wr_addr = pos_idx;
				wr_data = {1'b1, rd_link};
			end
			llsm_pkg::OP_POP_FRONT, llsm_pkg::OP_FREE_PTR: begin
				wr_en   = 1'b1;
				wr_data = {1'b0, free_q};
			end
			llsm_pkg::OP_WALK: begin
				wr_en     = 1'b1;
				wr_addr   = walk_q;
				wr_data   = {walk_q == IDX_ONE, walk_link};
				val_we    = (walk_q == IDX_ONE);
				val_waddr = walk_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// memories with registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem[wr_addr] <= wr_data;
		end
		if (val_we) begin
			val_mem[val_waddr] <= val_q;
		end
		if (rd_en) begin
			node_rd_q <= node_mem[rd_addr];
			val_rd_q  <= val_mem[rd_addr];
		end
	end

	// scratch pointers and command beat fields
	always_ff @(posedge clk) begin
		if (ctl.op == llsm_pkg::OP_LOAD) begin
			cmd_q <= req_cmd;
			pos_q <= req_position;
		end
		unique case (ctl.op)
			llsm_pkg::OP_RD_FREE: begin
				ptr_q   <= free_q;
				plink_q <= rd_link;
			end
			llsm_pkg::OP_RD_HEAD: begin
				ptr_q <= head_q;
			end
			llsm_pkg::OP_RD_DEL: begin
				ptr_q <= rd_link;
			end
			default: begin
				ptr_q <= ptr_q;
			end
		endcase
	end

	// list pointers, element count and init walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= IDX_ONE;
			tail_q  <= IDX_ONE;
			free_q  <= IDX_TWO;
			count_q <= IDX_ONE;
			walk_q  <= '0;
			val_q   <= '0;
		end else begin
			unique case (ctl.op)
				llsm_pkg::OP_LOAD: begin
					val_q <= DATA_WIDTH'(req_value);
				end
				llsm_pkg::OP_ALLOC_BACK: begin
					free_q  <= rd_link;
					count_q <= count_q + IDX_ONE;
					if (head_q == '0) begin
						head_q <= ptr_q;
						tail_q <= ptr_q;
					end
				end
				llsm_pkg::OP_ALLOC_FRONT: begin
					free_q  <= rd_link;
					count_q <= count_q + IDX_ONE;
					head_q  <= ptr_q;
					if (tail_q == '0) begin
						tail_q <= ptr_q;
					end
				end
				llsm_pkg::OP_ALLOC_AFTER: begin
					free_q  <= rd_link;
					count_q <= count_q + IDX_ONE;
					if (tail_q == pos_idx) begin
						tail_q <= ptr_q;
					end
				end
				llsm_pkg::OP_LINK_TAIL: begin
					tail_q <= ptr_q;
				end
				llsm_pkg::OP_POP_FRONT: begin
					head_q  <= rd_link;
					free_q  <= ptr_q;
					count_q <= count_q - IDX_ONE;
					if (rd_link == '0) begin
						tail_q <= '0;
					end
				end
				llsm_pkg::OP_UNLINK: begin
					if (tail_q == ptr_q) begin
						tail_q <= pos_idx;
					end
				end
				llsm_pkg::OP_FREE_PTR: begin
					free_q  <= ptr_q;
					count_q <= count_q - IDX_ONE;
				end
				llsm_pkg::OP_WALK: begin
					if (walk_last) begin
						walk_q  <= '0;
						head_q  <= IDX_ONE;
						tail_q  <= IDX_ONE;
						free_q  <= IDX_TWO;
						count_q <= IDX_ONE;
					end else begin
						walk_q <= walk_q + IDX_ONE;
					end
				end
				default: begin
					walk_q <= walk_q;
				end
			endcase
		end
	end

	// result register
	assign fin_ok = (ctl.fin_status == llsm_pkg::ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fin) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			rsp_status        <= ctl.fin_status;
			rsp_element_count <= COUNT_W'(count_q);
			if (!fin_ok) begin
				rsp_slot <= '0;
			end else if (cmd_q == llsm_pkg::CMD_READ) begin
				rsp_slot <= pos_q;
			end else if (cmd_q == llsm_pkg::CMD_INIT) begin
				rsp_slot <= SLOT_W'(1);
			end else begin
				rsp_slot <= SLOT_W'(ptr_q);
			end
			if (fin_ok && cmd_q == llsm_pkg::CMD_READ) begin
				rsp_read_value <= VALUE_W'($signed(val_rd_q));
			end else begin
				rsp_read_value <= '0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	// status back to the controller
	assign sts.cmd          = cmd_q;
	assign sts.pos_ok       = (pos_q != '0) && (int'(pos_q) < SLOTS);
	assign sts.used         = rd_used;
	assign sts.link_zero    = (rd_link == '0);
	assign sts.link_is_tail = (rd_link == tail_q);
	assign sts.free_zero    = (free_q == '0);
	assign sts.head_zero    = (head_q == '0);
	assign sts.walk_last    = walk_last;
	assign sts.out_stall    = out_valid_q && !rsp_ready;

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == '0) == (tail_q == '0))
		else $error("head and tail disagree on an empty list");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == '0) == (count_q == '0))
		else $error("element count disagrees with head pointer");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q == '0) == (count_q == IDX_LAST))
		else $error("free chain disagrees with element count");

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |=> out_valid_q)
		else $error("finished command produced no result beat");

endmodule

// ===== rtl/llsm_ctrl.sv =====
// command sequencer: decodes each command beat and steps the datapath
module llsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  llsm_pkg::llsm_sts_t sts,
	output llsm_pkg::llsm_ctl_t ctl
);

	localparam logic [3:0] S_BOOT      = 4'd0;
	localparam logic [3:0] S_IDLE      = 4'd1;
	localparam logic [3:0] S_DECODE    = 4'd2;
	localparam logic [3:0] S_PB_AL     = 4'd3;
	localparam logic [3:0] S_LINK_TAIL = 4'd4;
	localparam logic [3:0] S_PF_AL     = 4'd5;
	localparam logic [3:0] S_IA_CHK    = 4'd6;
	localparam logic [3:0] S_IA_AL     = 4'd7;
	localparam logic [3:0] S_IA_LN     = 4'd8;
	localparam logic [3:0] S_PO_FR     = 4'd9;
	localparam logic [3:0] S_DA_CHK    = 4'd10;
	localparam logic [3:0] S_DA_UN     = 4'd11;
	localparam logic [3:0] S_DA_FR     = 4'd12;
	localparam logic [3:0] S_RD_CHK    = 4'd13;
	localparam logic [3:0] S_WALK      = 4'd14;
	localparam logic [3:0] S_DONE      = 4'd15;

	logic [3:0]                    state_q;
	logic [3:0]                    state_d;
	logic [llsm_pkg::STATUS_W-1:0] res_q;
	logic [llsm_pkg::STATUS_W-1:0] res_d;

	// next state and datapath operation
	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		req_ready      = 1'b0;
		ctl.op         = llsm_pkg::OP_NONE;
		ctl.fin        = 1'b0;
		ctl.fin_status = res_q;
		unique case (state_q)
			S_BOOT: begin
				ctl.op = llsm_pkg::OP_WALK;
				if (sts.walk_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.op  = llsm_pkg::OP_LOAD;
					res_d   = llsm_pkg::ST_OK;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.cmd)
					llsm_pkg::CMD_PUSH_BACK, llsm_pkg::CMD_PUSH_FRONT: begin
						if (sts.free_zero) begin
							res_d   = llsm_pkg::ST_FULL;
							state_d = S_DONE;
						end else begin
							ctl.op  = llsm_pkg::OP_RD_FREE;
							state_d = (sts.cmd == llsm_pkg::CMD_PUSH_BACK) ? S_PB_AL : S_PF_AL;
						end
					end
					llsm_pkg::CMD_INSERT_AFTER, llsm_pkg::CMD_DELETE_AFTER,
					llsm_pkg::CMD_POP_BACK, llsm_pkg::CMD_READ: begin
						if (!sts.pos_ok) begin
							res_d   = llsm_pkg::ST_BAD;
							state_d = S_DONE;
						end else begin
							ctl.op = llsm_pkg::OP_RD_POS;
							if (sts.cmd == llsm_pkg::CMD_INSERT_AFTER) begin
								state_d = S_IA_CHK;
							end else if (sts.cmd == llsm_pkg::CMD_READ) begin
								state_d = S_RD_CHK;
							end else begin
								state_d = S_DA_CHK;
							end
						end
					end
					llsm_pkg::CMD_POP_FRONT: begin
						if (sts.head_zero) begin
							res_d   = llsm_pkg::ST_EMPTY;
							state_d = S_DONE;
						end else begin
							ctl.op  = llsm_pkg::OP_RD_HEAD;
							state_d = S_PO_FR;
						end
					end
					llsm_pkg::CMD_INIT: begin
						state_d = S_WALK;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_PB_AL: begin
				ctl.op  = llsm_pkg::OP_ALLOC_BACK;
				state_d = sts.head_zero ? S_DONE : S_LINK_TAIL;
			end
			S_LINK_TAIL: begin
				ctl.op  = llsm_pkg::OP_LINK_TAIL;
				state_d = S_DONE;
			end
			S_PF_AL: begin
				ctl.op  = llsm_pkg::OP_ALLOC_FRONT;
				state_d = S_DONE;
			end
			S_IA_CHK: begin
				priority if (!sts.used) begin
					res_d   = llsm_pkg::ST_BAD;
					state_d = S_DONE;
				end else if (sts.free_zero) begin
					res_d   = llsm_pkg::ST_FULL;
					state_d = S_DONE;
				end else begin
					ctl.op  = llsm_pkg::OP_RD_FREE;
					state_d = S_IA_AL;
				end
			end
			S_IA_AL: begin
				ctl.op  = llsm_pkg::OP_ALLOC_AFTER;
				state_d = S_IA_LN;
			end
			S_IA_LN: begin
				ctl.op  = llsm_pkg::OP_LINK_POS;
				state_d = S_DONE;
			end
			S_PO_FR: begin
				ctl.op  = llsm_pkg::OP_POP_FRONT;
				state_d = S_DONE;
			end
			S_DA_CHK: begin
				priority if (!sts.used) begin
					res_d   = llsm_pkg::ST_BAD;
					state_d = S_DONE;
				end else if (sts.link_zero) begin
					res_d   = llsm_pkg::ST_EMPTY;
					state_d = S_DONE;
				end else if (sts.cmd == llsm_pkg::CMD_POP_BACK && !sts.link_is_tail) begin
					res_d   = llsm_pkg::ST_BAD;
					state_d = S_DONE;
				end else begin
					ctl.op  = llsm_pkg::OP_RD_DEL;
					state_d = S_DA_UN;
				end
			end
			S_DA_UN: begin
				ctl.op  = llsm_pkg::OP_UNLINK;
				state_d = S_DA_FR;
			end
			S_DA_FR: begin
				ctl.op  = llsm_pkg::OP_FREE_PTR;
				state_d = S_DONE;
			end
			S_RD_CHK: begin
				if (!sts.used) begin
					res_d = llsm_pkg::ST_BAD;
				end
				state_d = S_DONE;
			end
			S_WALK: begin
				ctl.op = llsm_pkg::OP_WALK;
				if (sts.walk_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_stall) begin
					ctl.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
			res_q   <= llsm_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	a_fin_not_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |-> !sts.out_stall)
		else $error("result beat overwritten while still pending");

	a_boot_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BOOT |-> !req_ready && !ctl.fin)
		else $error("activity during the clearing pass");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !sts.out_stall) |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after finishing");

endmodule

// ===== rtl/linked_list_slot_manager_core.sv =====
// Singly linked list slot manager: one command beat in, one result beat out. After reset
// the block runs a clearing pass over every slot of the node memory and takes no command
// until it ends. Commands go one at a time through a sequencer that issues reads and
// writes to a single-port-read, single-port-write node memory (one link plus a used bit
// per slot) and a value memory. A slot out of range, a push with no free slot or a pop
// front on an empty list is refused straight from decode; the other refusals follow a
// read of the named slot. Init rewrites every slot, one per cycle. The block is ready
// for the next command in the same cycle that the result is first offered. A new
// command is accepted while a finished result still waits in the output register; its
// own result then waits until the earlier beat is taken.
module linked_list_slot_manager_core #(
	parameter int SLOTS      = llsm_pkg::SLOTS_DEF,
	parameter int DATA_WIDTH = llsm_pkg::DATA_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	llsm_cmd_if.sink   req,
	llsm_rsp_if.source rsp
);

	llsm_pkg::llsm_ctl_t ctl;
	llsm_pkg::llsm_sts_t sts;

	// command sequencer
	llsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// memories, pointers and result register
	llsm_datapath #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_cmd           (req.cmd),
		.req_value         (req.value),
		.req_position      (req.position),
		.rsp_ready         (rsp.ready),
		.rsp_valid         (rsp.valid),
		.rsp_slot          (rsp.slot),
		.rsp_read_value    (rsp.read_value),
		.rsp_element_count (rsp.element_count),
		.rsp_status        (rsp.status),
		.ctl               (ctl),
		.sts               (sts)
	);

endmodule

// ===== bench/linked_list_slot_manager_core_tb.sv =====
// testbench for the linked-list slot manager: random and directed commands checked per beat
`timescale 1ns / 1ps

module linked_list_slot_manager_core_tb;

	localparam int NSLOT      = llsm_pkg::SLOTS_DEF;
	localparam int ITEM_GOAL  = 900;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 40;

	localparam int CMD_W    = llsm_pkg::CMD_W;
	localparam int VALUE_W  = llsm_pkg::VALUE_W;
	localparam int POS_W    = llsm_pkg::POS_W;
	localparam int SLOT_W   = llsm_pkg::SLOT_W;
	localparam int COUNT_W  = llsm_pkg::COUNT_W;
	localparam int STATUS_W = llsm_pkg::STATUS_W;

	// stimulus flavors
	localparam int MODE_MIX   = 0;
	localparam int MODE_FILL  = 1;
	localparam int MODE_DRAIN = 2;
	localparam int MODE_NOISE = 3;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [VALUE_W-1:0]  rdval;
		logic [COUNT_W-1:0]  cnt;
		logic [STATUS_W-1:0] st;
	} list_rsp_t;

	// list state mirror, expected result queue and result checking
	class list_tracker_t;
		logic [VALUE_W-1:0] vals [NSLOT];
		logic [SLOT_W-1:0]  links [NSLOT];
		bit                 busy [NSLOT];
		logic [SLOT_W-1:0]  head, tail, free_ptr;
		logic [COUNT_W-1:0] n_elem;
		list_rsp_t          pending_rsp [$];
		int                 n_rsps, n_bad, n_shown;
		int                 st_seen [4];
		int                 cmd_seen [8];

		function new();
			rebuild('0);
		endfunction

		// fresh list: one element in slot 1, free chain 2..last
		function void rebuild(logic [VALUE_W-1:0] v);
			for (int s = 0; s < NSLOT; s++) begin
				vals[s] = '0;
				busy[s] = 1'b0;
				links[s] = (s >= 2 && s + 1 < NSLOT) ? SLOT_W'(s + 1) : '0;
			end
			vals[1] = v;
			busy[1] = 1'b1;
			head = SLOT_W'(1);
			tail = SLOT_W'(1);
			free_ptr = SLOT_W'(2);
			n_elem = COUNT_W'(1);
		endfunction

		function bit slot_ok(logic [POS_W-1:0] p);
			return p != 0 && int'(p) < NSLOT && busy[p];
		endfunction

		function logic [SLOT_W-1:0] grab(logic [VALUE_W-1:0] v);
			logic [SLOT_W-1:0] n;
			n = free_ptr;
			free_ptr = links[n];
			vals[n] = v;
			busy[n] = 1'b1;
			n_elem++;
			return n;
		endfunction

		function void retire(logic [SLOT_W-1:0] d);
			links[d] = free_ptr;
			free_ptr = d;
			busy[d] = 1'b0;
			vals[d] = '0;
			n_elem--;
		endfunction

		// accepted command beat: update the mirror and queue its result
		function void apply_cmd(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v,
			logic [POS_W-1:0] p);
			list_rsp_t r;
			logic [SLOT_W-1:0] n, d;
			r = '0;
			unique case (c)
				llsm_pkg::CMD_PUSH_BACK, llsm_pkg::CMD_PUSH_FRONT: begin
					if (free_ptr == 0) begin
						r.st = llsm_pkg::ST_FULL;
					end else begin
						n = grab(v);
						if (c == llsm_pkg::CMD_PUSH_BACK) begin
							links[n] = '0;
							if (head == 0) head = n;
							else links[tail] = n;
							tail = n;
						end else begin
							links[n] = head;
							head = n;
							if (tail == 0) tail = n;
						end
						r.slot = n;
					end
				end
				llsm_pkg::CMD_INSERT_AFTER: begin
					if (!slot_ok(p)) begin
						r.st = llsm_pkg::ST_BAD;
					end else if (free_ptr == 0) begin
						r.st = llsm_pkg::ST_FULL;
					end else begin
						n = grab(v);
						links[n] = links[p];
						links[p] = n;
						if (tail == p) tail = n;
						r.slot = n;
					end
				end
				llsm_pkg::CMD_POP_FRONT: begin
					if (head == 0) begin
						r.st = llsm_pkg::ST_EMPTY;
					end else begin
						d = head;
						head = links[d];
						if (head == 0) tail = '0;
						retire(d);
						r.slot = d;
					end
				end
				llsm_pkg::CMD_DELETE_AFTER, llsm_pkg::CMD_POP_BACK: begin
					if (!slot_ok(p)) begin
						r.st = llsm_pkg::ST_BAD;
					end else begin
						d = links[p];
						if (d == 0) begin
							r.st = llsm_pkg::ST_EMPTY;
						end else if (c == llsm_pkg::CMD_POP_BACK && d != tail) begin
							r.st = llsm_pkg::ST_BAD;
						end else begin
							links[p] = links[d];
							if (tail == d) tail = p;
							retire(d);
							r.slot = d;
						end
					end
				end
				llsm_pkg::CMD_READ: begin
					if (!slot_ok(p)) begin
						r.st = llsm_pkg::ST_BAD;
					end else begin
						r.rdval = vals[p];
						r.slot = p;
					end
				end
				llsm_pkg::CMD_INIT: begin
					rebuild(v);
					r.slot = SLOT_W'(1);
				end
			endcase
			r.cnt = n_elem;
			cmd_seen[c]++;
			st_seen[r.st]++;
			pending_rsp.push_back(r);
		endfunction

		// accepted result beat: compare with the oldest expectation
		function void compare_rsp(list_rsp_t got);
			list_rsp_t want;
			n_rsps++;
			if (pending_rsp.size() == 0) begin
				n_bad++;
				if (n_shown < 10) begin
					n_shown++;
					$display("unexpected result beat %0d: slot %0d value %h", n_rsps,
						got.slot, got.rdval, " count %0d code %0d", got.cnt, got.st);
				end
				return;
			end
			want = pending_rsp.pop_front();
			if (got.slot !== want.slot || got.rdval !== want.rdval ||
				got.cnt !== want.cnt || got.st !== want.st) begin
				n_bad++;
				if (n_shown < 10) begin
					n_shown++;
					$display("mismatch on result %0d (expected/actual): ", n_rsps,
						"slot %0d/%0d value %h/%h ", want.slot, got.slot,
						want.rdval, got.rdval,
						"count %0d/%0d code %0d/%0d", want.cnt, got.cnt,
						want.st, got.st);
				end
			end
		endfunction

		// list walks used to aim positions at live slots
		function logic [SLOT_W-1:0] nth_member(int k);
			logic [SLOT_W-1:0] s;
			s = head;
			repeat (k) s = links[s];
			return s;
		endfunction

		function logic [SLOT_W-1:0] any_member();
			if (n_elem == 0) return '0;
			return nth_member($urandom_range(n_elem - 1));
		endfunction

		function logic [SLOT_W-1:0] tail_pred();
			logic [SLOT_W-1:0] s;
			if (head == 0 || head == tail) return '0;
			s = head;
			while (links[s] != tail) s = links[s];
			return s;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   src_gaps = 1'b1;
	bit   rsp_gaps = 1'b1;
	bit   hold_req = 1'b0;
	int   n_sent = 0;

	list_tracker_t book = new();

	llsm_cmd_if req_if ();
	llsm_rsp_if rsp_if ();

	linked_list_slot_manager_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function logic [POS_W-1:0] pick_pos();
		int r;
		r = $urandom_range(99);
		if (r < 65) return book.any_member();
		if (r < 75) return book.tail;
		if (r < 82) return book.tail_pred();
		if (r < 85) return '0;
		return POS_W'($urandom_range(255));
	endfunction

	// choose the next command beat for a stimulus flavor
	task automatic pick_cmd(input int mode, output logic [CMD_W-1:0] c,
		output logic [VALUE_W-1:0] v, output logic [POS_W-1:0] p);
		int r;
		r = $urandom_range(99);
		v = pick_value();
		p = pick_pos();
		case (mode)
			MODE_FILL: begin
				if (r < 45) c = llsm_pkg::CMD_PUSH_BACK;
				else if (r < 70) c = llsm_pkg::CMD_PUSH_FRONT;
				else if (r < 90) c = llsm_pkg::CMD_INSERT_AFTER;
				else c = llsm_pkg::CMD_READ;
			end
			MODE_DRAIN: begin
				if (r < 35) c = llsm_pkg::CMD_POP_FRONT;
				else if (r < 60) begin
					c = llsm_pkg::CMD_DELETE_AFTER;
					p = book.any_member();
				end else if (r < 90) begin
					c = llsm_pkg::CMD_POP_BACK;
					p = book.tail_pred();
				end else c = llsm_pkg::CMD_READ;
			end
			MODE_NOISE: begin
				c = CMD_W'($urandom_range(7));
				v = $urandom;
				p = POS_W'($urandom_range(255));
			end
			default: begin
				if (r < 16) c = llsm_pkg::CMD_PUSH_BACK;
				else if (r < 28) c = llsm_pkg::CMD_PUSH_FRONT;
				else if (r < 42) c = llsm_pkg::CMD_INSERT_AFTER;
				else if (r < 52) c = llsm_pkg::CMD_POP_FRONT;
				else if (r < 64) c = llsm_pkg::CMD_DELETE_AFTER;
				else if (r < 74) begin
					c = llsm_pkg::CMD_POP_BACK;
					if ($urandom_range(3) != 0) p = book.tail_pred();
				end else if (r < 97) c = llsm_pkg::CMD_READ;
				else c = llsm_pkg::CMD_INIT;
			end
		endcase
	endtask

	// offer one command beat, note it once accepted, then maybe idle
	task automatic send_cmd(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
		int g;
		req_if.valid    <= 1'b1;
		req_if.cmd      <= c;
		req_if.value    <= v;
		req_if.position <= p;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		book.apply_cmd(c, v, p);
		n_sent++;
		if (src_gaps) begin
			g = gap_len();
			if (g > 0) begin
				req_if.valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic run_mode(int mode, int n);
		logic [CMD_W-1:0]   c;
		logic [VALUE_W-1:0] v;
		logic [POS_W-1:0]   p;
		repeat (n) begin
			pick_cmd(mode, c, v, p);
			send_cmd(c, v, p);
		end
	endtask

	// push until no slot is free, then hit the full case
	task automatic fill_list();
		logic [CMD_W-1:0]   c;
		logic [VALUE_W-1:0] v;
		logic [POS_W-1:0]   p;
		while (book.free_ptr != 0) begin
			pick_cmd(MODE_FILL, c, v, p);
			send_cmd(c, v, p);
		end
		send_cmd(llsm_pkg::CMD_PUSH_BACK, $urandom, POS_W'($urandom_range(255)));
		send_cmd(llsm_pkg::CMD_PUSH_FRONT, $urandom, POS_W'($urandom_range(255)));
		send_cmd(llsm_pkg::CMD_INSERT_AFTER, $urandom, book.any_member());
	endtask

	// remove until the list is empty, then send a pop front and a pop back to the empty list
	task automatic empty_list();
		logic [CMD_W-1:0]   c;
		logic [VALUE_W-1:0] v;
		logic [POS_W-1:0]   p;
		while (book.head != 0) begin
			pick_cmd(MODE_DRAIN, c, v, p);
			send_cmd(c, v, p);
		end
		send_cmd(llsm_pkg::CMD_POP_FRONT, $urandom, POS_W'($urandom_range(255)));
		send_cmd(llsm_pkg::CMD_POP_BACK, $urandom, POS_W'($urandom_range(255)));
	endtask

	// sender stops until every outstanding result has come back
	task automatic wait_results();
		req_if.valid <= 1'b0;
		while (book.pending_rsp.size() != 0) @(posedge clk);
	endtask

	// result side: check accepted beats and drive ready with stalls
	initial begin
		int run_left, stall_left, hold_left;
		list_rsp_t got;
		run_left = 0;
		stall_left = 0;
		hold_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				got.slot  = rsp_if.slot;
				got.rdval = rsp_if.read_value;
				got.cnt   = rsp_if.element_count;
				got.st    = rsp_if.status;
				book.compare_rsp(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = $urandom_range(150, 250);
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else if (rsp_gaps) begin
					stall_left = gap_len();
					run_left = $urandom_range(0, 12);
				end
			end
		end
	end

	// watchdog: too many cycles without any beat on either channel
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
				(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) idle = 0;
			else idle++;
		end
		$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		req_if.valid    <= 1'b0;
		req_if.cmd      <= llsm_pkg::CMD_READ;
		req_if.value    <= '0;
		req_if.position <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: bad slots, no successor, emptying and refilling the list
		send_cmd(llsm_pkg::CMD_READ, '0, 8'd1);
		send_cmd(llsm_pkg::CMD_READ, '1, 8'd0);
		send_cmd(llsm_pkg::CMD_READ, '0, 8'd255);
		send_cmd(llsm_pkg::CMD_DELETE_AFTER, '0, 8'd1);
		send_cmd(llsm_pkg::CMD_POP_BACK, '0, 8'd1);
		send_cmd(llsm_pkg::CMD_INSERT_AFTER, 32'h1234_5678, 8'd0);
		send_cmd(llsm_pkg::CMD_POP_FRONT, '0, 8'd0);
		send_cmd(llsm_pkg::CMD_POP_FRONT, '0, 8'd0);
		send_cmd(llsm_pkg::CMD_READ, '0, 8'd1);
		send_cmd(llsm_pkg::CMD_PUSH_BACK, 32'h7fff_ffff, 8'd0);
		send_cmd(llsm_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 8'd0);
		// tail repair on insert after the tail
		send_cmd(llsm_pkg::CMD_INSERT_AFTER, '1, book.tail);
		send_cmd(llsm_pkg::CMD_PUSH_BACK, '0, 8'd0);
		// wrong predecessor, then the right one
		send_cmd(llsm_pkg::CMD_POP_BACK, '0, book.head);
		send_cmd(llsm_pkg::CMD_POP_BACK, '0, book.tail_pred());
		// tail repair on delete of the tail
		send_cmd(llsm_pkg::CMD_DELETE_AFTER, '0, book.tail_pred());
		send_cmd(llsm_pkg::CMD_READ, '0, book.head);
		send_cmd(llsm_pkg::CMD_READ, '0, book.tail);
		send_cmd(llsm_pkg::CMD_INSERT_AFTER, '0, 8'd255);
		send_cmd(llsm_pkg::CMD_INIT, '1, 8'd0);
		send_cmd(llsm_pkg::CMD_READ, '0, 8'd1);
		send_cmd(llsm_pkg::CMD_PUSH_FRONT, 32'h5555_5555, 8'haa);
		send_cmd(llsm_pkg::CMD_PUSH_BACK, 32'haaaa_aaaa, 8'h55);
		send_cmd(llsm_pkg::CMD_READ, '0, book.head);
		send_cmd(llsm_pkg::CMD_READ, '0, book.tail);

		// random mix with idles on both sides
		run_mode(MODE_MIX, 150);

		// receiver holds off while commands keep coming
		src_gaps = 1'b0;
		hold_req = 1'b1;
		run_mode(MODE_MIX, 20);
		src_gaps = 1'b1;

		fill_list();

		// a stretch with no idling at all
		src_gaps = 1'b0;
		rsp_gaps = 1'b0;
		run_mode(MODE_DRAIN, 40);
		run_mode(MODE_MIX, 100);
		src_gaps = 1'b1;
		rsp_gaps = 1'b1;

		wait_results();
		run_mode(MODE_NOISE, 80);
		empty_list();
		while (n_sent < ITEM_GOAL) run_mode(MODE_MIX, 25);

		// let everything drain
		wait_results();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("run: %0d commands, %0d results; outcomes ok %0d full %0d empty %0d bad %0d",
			n_sent, book.n_rsps, book.st_seen[llsm_pkg::ST_OK],
			book.st_seen[llsm_pkg::ST_FULL], book.st_seen[llsm_pkg::ST_EMPTY],
			book.st_seen[llsm_pkg::ST_BAD]);
		$display("mix: pb %0d pf %0d ins %0d popf %0d del %0d popb %0d rd %0d init %0d; errors %0d",
			book.cmd_seen[llsm_pkg::CMD_PUSH_BACK], book.cmd_seen[llsm_pkg::CMD_PUSH_FRONT],
			book.cmd_seen[llsm_pkg::CMD_INSERT_AFTER], book.cmd_seen[llsm_pkg::CMD_POP_FRONT],
			book.cmd_seen[llsm_pkg::CMD_DELETE_AFTER], book.cmd_seen[llsm_pkg::CMD_POP_BACK],
			book.cmd_seen[llsm_pkg::CMD_READ], book.cmd_seen[llsm_pkg::CMD_INIT], book.n_bad);
		if (book.n_bad == 0 && book.pending_rsp.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== linked_list_slot_manager_core.f =====
rtl/llsm_pkg.sv
rtl/llsm_cmd_if.sv
rtl/llsm_rsp_if.sv
rtl/llsm_datapath.sv
rtl/llsm_ctrl.sv
rtl/linked_list_slot_manager_core.sv
bench/linked_list_slot_manager_core_tb.sv
